[hw/rtl/lirs_pkg.sv]
// Shared types and constants for the linear-interpolation stereo resampler.
package lirs_pkg;

    // Widths fixed by the sample and register formats.
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 33;
    localparam int STEP_W   = 32;
    localparam int CFG_ADDR_W = 1;

    // Default design parameters.
    localparam int MAX_RUN_DEF   = 64;
    localparam int FRAC_BITS_DEF = 24;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_RATIO_STEP = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MONO_INPUT = 1'b1;

    // Reset value of the phase increment (one at 24 fraction bits).
    localparam logic [STEP_W-1:0] RATIO_STEP_RESET = 32'h0100_0000;

    // Saturation limits.
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    // One output request issued by the sequencer into the lanes.
    typedef struct packed {
        logic valid;
        logic last;
    } issue_t;

endpackage

[hw/rtl/lirs_lane.sv]
// One interpolation lane: multiply stage, then truncate and saturate.
module lirs_lane #(
    parameter int FRAC_BITS = lirs_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] prev,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] cur,
    input  logic        [FRAC_BITS-1:0]          frac,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] result
);

    localparam int DIFF_W = lirs_pkg::SAMPLE_W + 1;
    localparam int NUM_W  = FRAC_BITS + lirs_pkg::SAMPLE_W + 2;
    localparam int Q_W    = lirs_pkg::SAMPLE_W + 2;

    logic signed [DIFF_W-1:0]            diff;
    logic signed [FRAC_BITS:0]           frac_s;
    logic signed [NUM_W-1:0]             prod_next;
    logic signed [NUM_W-1:0]             prod_reg;
    logic signed [lirs_pkg::SAMPLE_W-1:0] base_reg;
    logic signed [NUM_W-1:0]             base_ext;
    logic signed [NUM_W-1:0]             num;
    logic signed [Q_W-1:0]               q_floor;
    logic signed [Q_W-1:0]               q;
    logic                                round_up;

    // Stage one: slope times phase fraction.
    always_comb
    begin
        diff      = $signed({cur[lirs_pkg::SAMPLE_W-1], cur})
                  - $signed({prev[lirs_pkg::SAMPLE_W-1], prev});
        frac_s    = $signed({1'b0, frac});
        prod_next = NUM_W'(diff) * NUM_W'(frac_s);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            base_reg <= prev;
        end
    end

    // Stage two: add the base, divide by 2**FRAC_BITS with truncation toward zero, clamp.
    always_comb
    begin
        base_ext = $signed({{2{base_reg[lirs_pkg::SAMPLE_W-1]}}, base_reg,
                            {FRAC_BITS{1'b0}}});
        num      = base_ext + prod_reg;
        q_floor  = num[NUM_W-1:FRAC_BITS];
        round_up = num[NUM_W-1] && (|num[FRAC_BITS-1:0]);
        q        = q_floor + Q_W'(round_up);
        if (q > Q_W'(lirs_pkg::SAMPLE_MAX))
            result = lirs_pkg::SAMPLE_MAX;
        else if (q < Q_W'(lirs_pkg::SAMPLE_MIN))
            result = lirs_pkg::SAMPLE_MIN;
        else
            result = q[lirs_pkg::SAMPLE_W-1:0];
    end

endmodule

[hw/rtl/lirs_seq.sv]
// Frame history, phase accumulator, configuration and output sequencing.
module lirs_seq #(
    parameter int MAX_RUN   = lirs_pkg::MAX_RUN_DEF,
    parameter int FRAC_BITS = lirs_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic        [lirs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic        [lirs_pkg::STEP_W-1:0]     cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0]  left_in,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0]  right_in,
    input  logic                                  adv,
    output lirs_pkg::issue_t                      issue,
    output logic        [FRAC_BITS-1:0]           frac,
    output logic signed [lirs_pkg::SAMPLE_W-1:0]  prev_left,
    output logic signed [lirs_pkg::SAMPLE_W-1:0]  prev_right,
    output logic signed [lirs_pkg::SAMPLE_W-1:0]  cur_left,
    output logic signed [lirs_pkg::SAMPLE_W-1:0]  cur_right
);

    localparam int PW = lirs_pkg::PHASE_W;
    localparam int CW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam logic [PW-1:0] ONE_PHASE = PW'(1) << FRAC_BITS;
    localparam logic [CW-1:0] CNT_LAST  = CW'(MAX_RUN - 1);

    lirs_pkg::seq_state_t state_reg, state_next;

    logic [lirs_pkg::STEP_W-1:0]         ratio_step_reg;
    logic                                mono_input_reg;
    logic                                primed_reg;
    logic [PW-1:0]                       phase_reg, phase_next;
    logic [CW-1:0]                       cnt_reg, cnt_next;
    logic signed [lirs_pkg::SAMPLE_W-1:0] prev_l_reg, prev_r_reg, cur_l_reg, cur_r_reg;
    logic signed [lirs_pkg::SAMPLE_W-1:0] r_sel;
    logic                                accept;
    logic [PW-1:0]                       phase_start;
    logic [PW-1:0]                       phase_sum;
    logic                                start_run;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_step_reg <= lirs_pkg::RATIO_STEP_RESET;
            mono_input_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                lirs_pkg::REG_RATIO_STEP: ratio_step_reg <= cfg_wdata;
                lirs_pkg::REG_MONO_INPUT: mono_input_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Phase arithmetic for a new frame and for each output.
    always_comb
    begin
        accept      = in_valid && in_ready;
        r_sel       = mono_input_reg ? left_in : right_in;
        if (!primed_reg)
            phase_start = '0;
        else if (phase_reg >= ONE_PHASE)
            phase_start = phase_reg - ONE_PHASE;
        else
            phase_start = '0;
        start_run   = (phase_start[PW-1:FRAC_BITS] == '0);
        phase_sum   = phase_reg + PW'(ratio_step_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lirs_pkg::ST_IDLE:
                if (accept && start_run)
                    state_next = lirs_pkg::ST_RUN;
            lirs_pkg::ST_RUN:
                if (issue.valid && issue.last)
                    state_next = lirs_pkg::ST_IDLE;
            default:
                state_next = lirs_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready    = 1'b0;
        issue.valid = 1'b0;
        unique case (state_reg)
            lirs_pkg::ST_IDLE: in_ready    = 1'b1;
            lirs_pkg::ST_RUN:  issue.valid = adv;
            default: ;
        endcase
        issue.last = (phase_sum[PW-1:FRAC_BITS] != '0) || (cnt_reg == CNT_LAST);
        frac       = phase_reg[FRAC_BITS-1:0];
    end

    // Phase and run counter updates.
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            phase_next = phase_start;
            cnt_next   = '0;
        end
        else if (issue.valid)
        begin
            phase_next = phase_sum;
            cnt_next   = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lirs_pkg::ST_IDLE;
            phase_reg  <= '0;
            cnt_reg    <= '0;
            primed_reg <= 1'b0;
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            cur_l_reg  <= '0;
            cur_r_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (accept)
            begin
                primed_reg <= 1'b1;
                prev_l_reg <= primed_reg ? cur_l_reg : left_in;
                prev_r_reg <= primed_reg ? cur_r_reg : r_sel;
                cur_l_reg  <= left_in;
                cur_r_reg  <= r_sel;
            end
        end
    end

    assign prev_left  = prev_l_reg;
    assign prev_right = prev_r_reg;
    assign cur_left   = cur_l_reg;
    assign cur_right  = cur_r_reg;

    // While a run is active the phase is below one.
    a_run_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lirs_pkg::ST_RUN |-> phase_reg[PW-1:FRAC_BITS] == '0)
        else $error("phase at or above one during a run");

    // The final output of a run returns the sequencer to idle.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid && issue.last |=> state_reg == lirs_pkg::ST_IDLE)
        else $error("run continued after its last output");

    // A run issues only while the sequencer is in a run.
    a_issue_run: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid |-> !in_ready && adv)
        else $error("output issued outside a run");

    // A frame that opens a run clears the run counter.
    a_cnt_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && start_run |=> cnt_reg == '0 && state_reg == lirs_pkg::ST_RUN)
        else $error("run did not start cleanly");

endmodule

[hw/rtl/linear_interp_stereo_resampler_top.sv]
// Top level of the linear-interpolation stereo resampler: lanes and merge stage.
// Path: sequencer run state, lanes' multiply stage, merge stage output register.
// Throughput: one output frame per cycle during a run while the output side accepts;
// a frame is taken only while the sequencer is idle and causes up to MAX_RUN outputs,
// issued one phase step per cycle into the left and right lanes while adv is high.
// Reset (rst_n, asynchronous, active low) clears history, phase and valid flags.
module linear_interp_stereo_resampler_top #(
    parameter int MAX_RUN   = lirs_pkg::MAX_RUN_DEF,
    parameter int FRAC_BITS = lirs_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [lirs_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [lirs_pkg::STEP_W-1:0]            cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [2*lirs_pkg::SAMPLE_W-1:0]        s_tdata,  // right_in (upper half), left_in (lower half)
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [2*lirs_pkg::SAMPLE_W-1:0]        m_tdata,  // right_out (upper half), left_out (lower half)
    output logic                                   m_tlast
);

    localparam int SW = lirs_pkg::SAMPLE_W;

    lirs_pkg::issue_t       issue;
    logic                   adv;
    logic [FRAC_BITS-1:0]   frac;
    logic signed [SW-1:0]   prev_left, prev_right, cur_left, cur_right;
    logic signed [SW-1:0]   left_res, right_res;
    logic                   s1_valid_reg, s1_last_reg;
    logic                   out_valid_reg, out_last_reg;
    logic signed [SW-1:0]   out_left_reg, out_right_reg;

    // Everything advances when the output register is free or being taken.
    assign adv = !out_valid_reg || m_tready;

    lirs_seq #(
        .MAX_RUN   (MAX_RUN),
        .FRAC_BITS (FRAC_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .left_in    ($signed(s_tdata[SW-1:0])),
        .right_in   ($signed(s_tdata[2*SW-1:SW])),
        .adv        (adv),
        .issue      (issue),
        .frac       (frac),
        .prev_left  (prev_left),
        .prev_right (prev_right),
        .cur_left   (cur_left),
        .cur_right  (cur_right)
    );

    lirs_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_left (
        .clk    (clk),
        .en     (adv),
        .prev   (prev_left),
        .cur    (cur_left),
        .frac   (frac),
        .result (left_res)
    );

    lirs_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_right (
        .clk    (clk),
        .en     (adv),
        .prev   (prev_right),
        .cur    (cur_right),
        .frac   (frac),
        .result (right_res)
    );

    // Valid and last flags follow the lanes' multiply stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= issue.valid;
            s1_last_reg   <= issue.last;
            out_valid_reg <= s1_valid_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    // Merge stage: both lanes' results form one output frame.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_left_reg  <= left_res;
            out_right_reg <= right_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_right_reg, out_left_reg};
    assign m_tlast  = out_last_reg;

endmodule

[test/tb_linear_interp_stereo_resampler_top.sv]
// Self-checking testbench for the linear-interpolation stereo resampler top level.
module tb_linear_interp_stereo_resampler_top;

    // Widths, limits and register indexes taken from the shared package.
    localparam int SAMPLE_W   = lirs_pkg::SAMPLE_W;
    localparam int STEP_W     = lirs_pkg::STEP_W;
    localparam int PHASE_W    = lirs_pkg::PHASE_W;
    localparam int CFG_ADDR_W = lirs_pkg::CFG_ADDR_W;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX       = lirs_pkg::SAMPLE_MAX;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN       = lirs_pkg::SAMPLE_MIN;
    localparam logic [CFG_ADDR_W-1:0]      REG_RATIO_STEP   = lirs_pkg::REG_RATIO_STEP;
    localparam logic [CFG_ADDR_W-1:0]      REG_MONO_INPUT   = lirs_pkg::REG_MONO_INPUT;
    localparam logic [STEP_W-1:0]          RATIO_STEP_RESET = lirs_pkg::RATIO_STEP_RESET;

    localparam int          RUN_CAP        = lirs_pkg::MAX_RUN_DEF;
    localparam longint      PHASE_ONE      = longint'(1) << lirs_pkg::FRAC_BITS_DEF;
    localparam int          SETTLE_CYCLES  = 2 * RUN_CAP + 8;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          NUM_DIRECTED   = 28;
    localparam int          NUM_PHASES     = 7;

    // One resampled output frame as it leaves the block.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } out_frame_t;

    typedef enum logic {
        ROW_FRAME,
        ROW_CONFIG
    } row_kind_t;

    // One line of the directed stimulus table.
    typedef struct packed {
        row_kind_t                  kind;
        logic [STEP_W-1:0]          step;
        logic                       mono;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       known;
        logic signed [SAMPLE_W-1:0] first_left;
        logic signed [SAMPLE_W-1:0] first_right;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_ADDR_W-1:0]       cfg_addr;
    logic [STEP_W-1:0]           cfg_wdata;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [2*SAMPLE_W-1:0]       s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [2*SAMPLE_W-1:0]       m_tdata;
    logic                        m_tlast;

    // Predictor state, mirrored from the block's registers and history.
    logic signed [SAMPLE_W-1:0]  hist_prev_l;
    logic signed [SAMPLE_W-1:0]  hist_prev_r;
    logic signed [SAMPLE_W-1:0]  hist_cur_l;
    logic signed [SAMPLE_W-1:0]  hist_cur_r;
    logic [PHASE_W-1:0]          phase_acc;
    bit                          history_primed;
    logic [STEP_W-1:0]           ratio_step;
    logic                        mono_mode;

    out_frame_t                  resampled_q[$];
    out_frame_t                  first_predicted;
    int                          predicted_count;
    int                          mismatches;
    int                          quiet_cycles;
    int                          src_idle_pct;
    int                          snk_idle_pct;
    bit                          hold_req;
    stim_row_t                   directed_rows [0:NUM_DIRECTED-1];

    linear_interp_stereo_resampler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Linear interpolation between two samples, truncated toward zero and clamped.
    function automatic logic signed [SAMPLE_W-1:0] interp_sample(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic [PHASE_W-1:0]         frac
    );
        longint num;
        longint q;
        num = longint'(a) * PHASE_ONE + (longint'(b) - longint'(a)) * longint'(frac);
        q = num / PHASE_ONE;
        if (q > longint'(SAMPLE_MAX))
            q = longint'(SAMPLE_MAX);
        if (q < longint'(SAMPLE_MIN))
            q = longint'(SAMPLE_MIN);
        return q[SAMPLE_W-1:0];
    endfunction

    // Advance the predictor by one accepted input frame and queue its outputs.
    function automatic void resample_frame(
        input logic signed [SAMPLE_W-1:0] l,
        input logic signed [SAMPLE_W-1:0] r
    );
        logic signed [SAMPLE_W-1:0] rr;
        out_frame_t                 res;
        int                         n;
        rr = mono_mode ? l : r;
        if (!history_primed)
        begin
            hist_prev_l    = l;
            hist_prev_r    = rr;
            phase_acc      = '0;
            history_primed = 1'b1;
        end
        else
        begin
            hist_prev_l = hist_cur_l;
            hist_prev_r = hist_cur_r;
            phase_acc   = (longint'(phase_acc) >= PHASE_ONE) ?
                          phase_acc - PHASE_W'(PHASE_ONE) : '0;
        end
        hist_cur_l = l;
        hist_cur_r = rr;
        n = 0;
        while (longint'(phase_acc) < PHASE_ONE && n < RUN_CAP)
        begin
            res.left  = interp_sample(hist_prev_l, hist_cur_l, phase_acc);
            res.right = interp_sample(hist_prev_r, hist_cur_r, phase_acc);
            phase_acc = phase_acc + PHASE_W'(ratio_step);
            n++;
            res.last  = !(longint'(phase_acc) < PHASE_ONE && n < RUN_CAP);
            if (n == 1)
                first_predicted = res;
            resampled_q.push_back(res);
        end
        predicted_count = n;
    endfunction

    // Random sample value, biased toward the extremes and small values.
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_W'($urandom_range(0, 8)) - SAMPLE_W'(4);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one frame after a random gap and wait for its request to be accepted.
    task automatic send_frame(
        input logic signed [SAMPLE_W-1:0] l,
        input logic signed [SAMPLE_W-1:0] r
    );
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        resample_frame(l, r);
    endtask

    // Stop offering, wait until every predicted output has arrived, then let the block settle.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (resampled_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers on consecutive cycles; the block must be idle.
    task automatic configure(input logic [STEP_W-1:0] step, input logic mono);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_RATIO_STEP;
        cfg_wdata <= step;
        @(posedge clk);
        cfg_addr  <= REG_MONO_INPUT;
        cfg_wdata <= STEP_W'(mono);
        @(posedge clk);
        cfg_we     <= 1'b0;
        ratio_step = step;
        mono_mode  = mono;
    endtask

    // Output side: random backpressure, plus one long hold-off on demand.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // Compare each accepted output frame with the oldest prediction.
    always @(posedge clk)
    begin
        out_frame_t exp_frame;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (resampled_q.size() == 0)
            begin
                $error("output frame with nothing predicted: left_out %0d right_out %0d",
                       $signed(m_tdata[SAMPLE_W-1:0]), $signed(m_tdata[2*SAMPLE_W-1:SAMPLE_W]));
                mismatches++;
            end
            else
            begin
                exp_frame = resampled_q.pop_front();
                if (m_tdata[SAMPLE_W-1:0] !== exp_frame.left)
                begin
                    $error("left_out expected %0d actual %0d", exp_frame.left,
                           $signed(m_tdata[SAMPLE_W-1:0]));
                    mismatches++;
                end
                if (m_tdata[2*SAMPLE_W-1:SAMPLE_W] !== exp_frame.right)
                begin
                    $error("right_out expected %0d actual %0d", exp_frame.right,
                           $signed(m_tdata[2*SAMPLE_W-1:SAMPLE_W]));
                    mismatches++;
                end
                if (m_tlast !== exp_frame.last)
                begin
                    $error("last expected %0d actual %0d", exp_frame.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without any request accepted on either side ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [STEP_W-1:0] step;
        logic              mono;
        int                frames;
        int                idx;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        hist_prev_l    = '0;
        hist_prev_r    = '0;
        hist_cur_l     = '0;
        hist_cur_r     = '0;
        phase_acc      = '0;
        history_primed = 1'b0;
        ratio_step     = RATIO_STEP_RESET;
        mono_mode      = 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        hold_req       = 1'b0;
        src_idle_pct   = 34;
        snk_idle_pct   = 85;

        // Directed table. At a step of one the output of each frame is the previous
        // frame; a zero step keeps the phase at zero, so a capped run repeats prev.
        directed_rows = '{
            '{ROW_FRAME,  '0, 1'b0, 16'sd100,    -16'sd200,   1'b1, 16'sd100,    -16'sd200},
            '{ROW_FRAME,  '0, 1'b0, SAMPLE_MAX,  SAMPLE_MIN,  1'b1, 16'sd100,    -16'sd200},
            '{ROW_FRAME,  '0, 1'b0, SAMPLE_MIN,  SAMPLE_MAX,  1'b1, SAMPLE_MAX,  SAMPLE_MIN},
            '{ROW_FRAME,  '0, 1'b0, -16'sd1,     16'sd1,      1'b1, SAMPLE_MIN,  SAMPLE_MAX},
            '{ROW_CONFIG, 32'h0040_0000, 1'b0, '0, '0, 1'b0, '0, '0},
            '{ROW_FRAME,  '0, 1'b0, SAMPLE_MAX,  SAMPLE_MIN,  1'b1, -16'sd1,     16'sd1},
            '{ROW_FRAME,  '0, 1'b0, SAMPLE_MIN,  SAMPLE_MAX,  1'b1, SAMPLE_MAX,  SAMPLE_MIN},
            '{ROW_FRAME,  '0, 1'b0, 16'sd0,      16'sd0,      1'b0, '0,          '0},
            '{ROW_CONFIG, 32'h0004_0000, 1'b1, '0, '0, 1'b0, '0, '0},
            '{ROW_FRAME,  '0, 1'b0, 16'sd12345,  -16'sd999,   1'b0, '0,          '0},
            '{ROW_FRAME,  '0, 1'b0, SAMPLE_MIN,  16'sd5,      1'b0, '0,          '0},
            '{ROW_CONFIG, 32'h0000_0000, 1'b0, '0, '0, 1'b0, '0, '0},
            '{ROW_FRAME,  '0, 1'b0, SAMPLE_MAX,  SAMPLE_MAX,  1'b1, SAMPLE_MIN,  SAMPLE_MIN},
            '{ROW_FRAME,  '0, 1'b0, SAMPLE_MIN,  SAMPLE_MIN,  1'b1, SAMPLE_MAX,  SAMPLE_MAX},
            '{ROW_CONFIG, 32'd100000,    1'b1, '0, '0, 1'b0, '0, '0},
            '{ROW_FRAME,  '0, 1'b0, 16'sd500,    -16'sd500,   1'b0, '0,          '0},
            '{ROW_FRAME,  '0, 1'b0, -16'sd7,     16'sd7,      1'b0, '0,          '0},
            '{ROW_CONFIG, 32'h0380_0000, 1'b0, '0, '0, 1'b0, '0, '0},
            '{ROW_FRAME,  '0, 1'b0, 16'sd1000,   -16'sd1000,  1'b0, '0,          '0},
            '{ROW_FRAME,  '0, 1'b0, 16'sh5555,   16'shAAAA,   1'b0, '0,          '0},
            '{ROW_FRAME,  '0, 1'b0, 16'shAAAA,   16'sh5555,   1'b0, '0,          '0},
            '{ROW_FRAME,  '0, 1'b0, SAMPLE_MAX,  SAMPLE_MIN,  1'b0, '0,          '0},
            '{ROW_FRAME,  '0, 1'b0, SAMPLE_MIN,  SAMPLE_MAX,  1'b0, '0,          '0},
            '{ROW_FRAME,  '0, 1'b0, 16'sd0,      -16'sd1,     1'b0, '0,          '0},
            '{ROW_FRAME,  '0, 1'b0, -16'sd1,     16'sd0,      1'b0, '0,          '0},
            '{ROW_FRAME,  '0, 1'b0, 16'sd321,    -16'sd321,   1'b0, '0,          '0},
            '{ROW_FRAME,  '0, 1'b0, 16'sd4096,   -16'sd4096,  1'b0, '0,          '0},
            '{ROW_FRAME,  '0, 1'b0, SAMPLE_MAX,  SAMPLE_MAX,  1'b0, '0,          '0}
        };

        // Single reset at the start of the run.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, sender idling lightly and receiver heavily.
        for (idx = 0; idx < NUM_DIRECTED; idx++)
        begin
            if (directed_rows[idx].kind == ROW_CONFIG)
            begin
                drain_outputs();
                configure(directed_rows[idx].step, directed_rows[idx].mono);
            end
            else
            begin
                send_frame(directed_rows[idx].left, directed_rows[idx].right);
                if (directed_rows[idx].known && predicted_count > 0)
                begin
                    if (first_predicted.left !== directed_rows[idx].first_left)
                    begin
                        $error("left_out expected %0d actual %0d",
                               directed_rows[idx].first_left, first_predicted.left);
                        mismatches++;
                    end
                    if (first_predicted.right !== directed_rows[idx].first_right)
                    begin
                        $error("right_out expected %0d actual %0d",
                               directed_rows[idx].first_right, first_predicted.right);
                        mismatches++;
                    end
                end
            end
        end

        // Random phases, each with its own step and channel mode.
        for (idx = 0; idx < NUM_PHASES; idx++)
        begin
            drain_outputs();
            frames = 26;
            mono   = idx[0];
            case (idx)
                0, 1: step = $urandom_range(32'h0004_0000, 32'h0100_0000);
                2:    step = $urandom_range(32'h0100_0000, 32'h0400_0000);
                3:
                begin
                    // Below one over the run cap: capped runs and a clamped phase drop.
                    step   = $urandom_range(0, 32'h0003_FFFF);
                    frames = 10;
                end
                4:    step = $urandom_range(32'h0004_0000, 32'h0300_0000);
                5:    step = RATIO_STEP_RESET + STEP_W'($urandom_range(0, 64)) - STEP_W'(32);
                default:
                begin
                    // Largest step last: after one output the phase stays far above one.
                    step   = '1;
                    frames = 8;
                end
            endcase
            if (idx < 2)
            begin
                src_idle_pct = 34;
                snk_idle_pct = 85;
            end
            else if (idx < 4)
            begin
                src_idle_pct = 85;
                snk_idle_pct = 34;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            configure(step, mono);
            if (idx == 1)
                hold_req = 1'b1;
            repeat (frames)
                send_frame(rand_sample(), rand_sample());
        end

        drain_outputs();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lirs_pkg.sv
hw/rtl/lirs_lane.sv
hw/rtl/lirs_seq.sv
hw/rtl/linear_interp_stereo_resampler_top.sv
test/tb_linear_interp_stereo_resampler_top.sv
